### sv/joint_pid_with_mode_toggle_defines.svh
// Assertion macros used by the joint PID controller sequencer.
`ifndef JOINT_PID_WITH_MODE_TOGGLE_DEFINES_SVH
`define JOINT_PID_WITH_MODE_TOGGLE_DEFINES_SVH

// Check that a condition holds in the same cycle as its trigger.
`define JPID_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define JPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/jpid_pkg.sv
// Shared types and constants of the joint PID controller.
package jpid_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int ACC_WIDTH_DEF = 48;

   localparam int WORD_W    = 32;
   localparam int LIMIT_W   = 31;
   localparam int DT_W      = 24;
   localparam int CNT_W     = 8;
   localparam int CSR_IDX_W = 3;
   localparam int MUL_W     = 33;
   localparam int PROD_W    = 2 * MUL_W;

   localparam logic [WORD_W-1:0]  PROP_GAIN_RST   = 32'd65536000;
   localparam logic [WORD_W-1:0]  INTEG_GAIN_RST  = 32'd655;
   localparam logic [WORD_W-1:0]  DERIV_GAIN_RST  = 32'd6554;
   localparam logic [LIMIT_W-1:0] INTEG_CLAMP_RST = 31'd65536000;
   localparam logic [LIMIT_W-1:0] ERROR_LIMIT_RST = 31'd655360;
   localparam logic [WORD_W-1:0]  OUT_SCALE_RST   = 32'd655;
   localparam logic [CNT_W-1:0]   PRESS_THR_RST   = 8'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROP_GAIN       = 3'd0,
      CSR_INTEG_GAIN      = 3'd1,
      CSR_DERIV_GAIN      = 3'd2,
      CSR_INTEG_CLAMP     = 3'd3,
      CSR_ERROR_LIMIT     = 3'd4,
      CSR_OUTPUT_SCALE    = 3'd5,
      CSR_PRESS_THRESHOLD = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_TICK     = 1'b0,
      OP_JOYSTICK = 1'b1
   } operation_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_JOY,
      ST_MODE,
      ST_ERR,
      ST_MIDT,
      ST_MP,
      ST_MI,
      ST_MD,
      ST_SUM,
      ST_MS,
      ST_DRV
   } state_type;

   typedef enum logic [2:0] {
      MS_IDT,
      MS_P,
      MS_I,
      MS_D,
      MS_S
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_req;
      logic        count_step;
      logic        mode_step;
      logic        prep;
      logic        mul_en;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        latch_idt;
      logic        latch_sum;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic hybrid;
   } dp_status_type;

endpackage

### sv/jpid_ctrl.sv
// Sequencer of the joint PID controller: handshakes and datapath commands.
`include "joint_pid_with_mode_toggle_defines.svh"

module jpid_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_operation,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  jpid_pkg::dp_status_type status,
   output jpid_pkg::dp_cmd_type    cmd
);

   jpid_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         jpid_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (req_operation == jpid_pkg::OP_JOYSTICK) begin
                  state_in = jpid_pkg::ST_JOY;
               end else begin
                  state_in = jpid_pkg::ST_MODE;
               end
            end
         end
         jpid_pkg::ST_JOY:  state_in = jpid_pkg::ST_IDLE;
         jpid_pkg::ST_MODE: state_in = jpid_pkg::ST_ERR;
         jpid_pkg::ST_ERR: begin
            state_in = status.hybrid ? jpid_pkg::ST_DRV : jpid_pkg::ST_MIDT;
         end
         jpid_pkg::ST_MIDT: state_in = jpid_pkg::ST_MP;
         jpid_pkg::ST_MP:   state_in = jpid_pkg::ST_MI;
         jpid_pkg::ST_MI:   state_in = jpid_pkg::ST_MD;
         jpid_pkg::ST_MD:   state_in = jpid_pkg::ST_SUM;
         jpid_pkg::ST_SUM:  state_in = jpid_pkg::ST_MS;
         jpid_pkg::ST_MS:   state_in = jpid_pkg::ST_DRV;
         jpid_pkg::ST_DRV: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = jpid_pkg::ST_IDLE;
            end
         end
         default: state_in = jpid_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         jpid_pkg::ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         jpid_pkg::ST_JOY:  cmd.count_step = 1'b1;
         jpid_pkg::ST_MODE: cmd.mode_step = 1'b1;
         jpid_pkg::ST_ERR:  cmd.prep = !status.hybrid;
         jpid_pkg::ST_MIDT: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jpid_pkg::MS_IDT;
         end
         jpid_pkg::ST_MP: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = jpid_pkg::MS_P;
            cmd.latch_idt = 1'b1;
         end
         jpid_pkg::ST_MI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jpid_pkg::MS_I;
            cmd.acc_op  = jpid_pkg::ACC_LOAD;
         end
         jpid_pkg::ST_MD: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jpid_pkg::MS_D;
            cmd.acc_op  = jpid_pkg::ACC_ADD;
         end
         jpid_pkg::ST_SUM: cmd.latch_sum = 1'b1;
         jpid_pkg::ST_MS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = jpid_pkg::MS_S;
         end
         jpid_pkg::ST_DRV: cmd.out_load = !rsp_valid_ff || rsp_ready;
         default: cmd = '0;
      endcase
   end

   // Hold the result until taken; a new load may replace one leaving now.
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jpid_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `JPID_ASSERT_SAME(a_no_overwrite, clock, reset, rsp_valid && !rsp_ready, !cmd.out_load, "result overwritten while pending")
   `JPID_ASSERT_NEXT(a_tick_start, clock, reset, req_valid && req_ready && req_operation == jpid_pkg::OP_TICK, state_ff == jpid_pkg::ST_MODE, "tick did not start mode update")
   `JPID_ASSERT_NEXT(a_load_shows, clock, reset, cmd.out_load, rsp_valid, "loaded result not presented")

endmodule

### sv/jpid_datapath.sv
// Datapath of the joint PID controller: settings, state, shared multiplier.
module jpid_datapath #(
   parameter int FRAC_BITS = jpid_pkg::FRAC_BITS_DEF,
   parameter int ACC_WIDTH = jpid_pkg::ACC_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  jpid_pkg::dp_cmd_type                 cmd,
   output jpid_pkg::dp_status_type              status,
   input  logic                                csr_write,
   input  logic [jpid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jpid_pkg::WORD_W-1:0]          csr_wdata,
   input  logic signed [jpid_pkg::WORD_W-1:0]   req_joint_angle,
   input  logic signed [jpid_pkg::WORD_W-1:0]   req_joint_velocity,
   input  logic [jpid_pkg::DT_W-1:0]            req_time_step,
   input  logic                                req_button_down,
   output logic signed [jpid_pkg::WORD_W-1:0]   rsp_drive,
   output logic                                rsp_drive_valid,
   output logic                                rsp_hybrid_mode
);

   localparam int W  = jpid_pkg::WORD_W;
   localparam int MW = jpid_pkg::MUL_W;
   localparam int PW = jpid_pkg::PROD_W;

   localparam logic signed [PW-1:0] PW_MAX = $signed({{(PW-W){1'b0}}, 1'b0, {(W-1){1'b1}}});
   localparam logic signed [PW-1:0] PW_MIN = $signed({{(PW-W){1'b1}}, 1'b1, {(W-1){1'b0}}});
   localparam logic signed [W:0]    E_MAX  = $signed({2'b00, {(W-1){1'b1}}});
   localparam logic [jpid_pkg::CNT_W-1:0] CNT_MAX = '1;

   function automatic logic signed [W-1:0] sat_word(input logic signed [PW-1:0] x);
      logic signed [W-1:0] r;
      if (x > PW_MAX) begin
         r = PW_MAX[W-1:0];
      end else if (x < PW_MIN) begin
         r = PW_MIN[W-1:0];
      end else begin
         r = x[W-1:0];
      end
      return r;
   endfunction

   // settings
   logic signed [W-1:0]               kp_ff, ki_ff, kd_ff, scale_ff;
   logic [jpid_pkg::LIMIT_W-1:0]      clamp_ff, elim_ff;
   logic [jpid_pkg::CNT_W-1:0]        thr_ff;

   // controller state
   logic [jpid_pkg::CNT_W-1:0]        count_ff, count_in;
   logic                              mode_ff, mode_in;
   logic signed [ACC_WIDTH-1:0]       integ_ff, integ_in;

   // request and work registers
   logic signed [W-1:0]               angle_ff, vel_ff;
   logic [jpid_pkg::DT_W-1:0]         dt_ff;
   logic                              button_ff;
   logic signed [W-1:0]               err_ff, err_in;
   logic signed [W-1:0]               idt_ff, sum_ff;
   logic signed [PW-1:0]              acc_ff, acc_in;
   logic signed [PW-1:0]              prod_ff, prod_in;
   logic signed [W-1:0]               drive_ff, drive_in;
   logic                              dvalid_ff, hyb_ff;

   logic signed [W:0]                 e_neg, e_sat, lim_s, e_lim;
   logic signed [ACC_WIDTH-1:0]       clamp_ext;
   logic                              integ_over;
   logic signed [ACC_WIDTH:0]         integ_wide;
   logic signed [ACC_WIDTH-1:0]       integ_sat;
   logic signed [MW-1:0]              mul_a, mul_b;
   logic signed [PW-1:0]              fx_prod, diff;

   assign status.hybrid = mode_ff;

   // error: negate, saturate, then clamp to the limit when it is nonzero
   always_comb begin
      e_neg = -$signed({angle_ff[W-1], angle_ff});
      e_sat = (e_neg > E_MAX) ? E_MAX : e_neg;
      lim_s = $signed({2'b00, elim_ff});
      e_lim = e_sat;
      if (elim_ff != '0) begin
         if (e_sat > lim_s) begin
            e_lim = lim_s;
         end else if (e_sat < -lim_s) begin
            e_lim = -lim_s;
         end
      end
      err_in = e_lim[W-1:0];
   end

   assign clamp_ext  = $signed({{(ACC_WIDTH-jpid_pkg::LIMIT_W){1'b0}}, clamp_ff});
   assign integ_over = (integ_ff > clamp_ext) || (integ_ff < -clamp_ext);

   always_comb begin
      integ_wide = $signed({integ_ff[ACC_WIDTH-1], integ_ff})
                 + $signed({{(ACC_WIDTH+1-W){err_ff[W-1]}}, err_ff});
      if (integ_wide[ACC_WIDTH] != integ_wide[ACC_WIDTH-1]) begin
         integ_sat = integ_wide[ACC_WIDTH] ? $signed({1'b1, {(ACC_WIDTH-1){1'b0}}})
                                           : $signed({1'b0, {(ACC_WIDTH-1){1'b1}}});
      end else begin
         integ_sat = integ_wide[ACC_WIDTH-1:0];
      end
   end

   always_comb begin
      integ_in = integ_ff;
      if (cmd.prep && integ_over) begin
         integ_in = '0;
      end
      if (cmd.latch_sum) begin
         integ_in = integ_sat;
      end
   end

   always_comb begin
      count_in = count_ff;
      mode_in  = mode_ff;
      if (cmd.count_step && button_ff && (count_ff != CNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.mode_step && (count_ff >= thr_ff)) begin
         count_in = '0;
         mode_in  = !mode_ff;
      end
   end

   // shared multiplier; the integral is within the clamp, so 32 bits hold it
   always_comb begin
      case (cmd.mul_sel)
         jpid_pkg::MS_IDT: begin
            mul_a = $signed({{(MW-W){integ_ff[W-1]}}, integ_ff[W-1:0]});
            mul_b = $signed({{(MW-jpid_pkg::DT_W){1'b0}}, dt_ff});
         end
         jpid_pkg::MS_P: begin
            mul_a = $signed({{(MW-W){err_ff[W-1]}}, err_ff});
            mul_b = $signed({{(MW-W){kp_ff[W-1]}}, kp_ff});
         end
         jpid_pkg::MS_I: begin
            mul_a = $signed({{(MW-W){idt_ff[W-1]}}, idt_ff});
            mul_b = $signed({{(MW-W){ki_ff[W-1]}}, ki_ff});
         end
         jpid_pkg::MS_D: begin
            mul_a = $signed({{(MW-W){vel_ff[W-1]}}, vel_ff});
            mul_b = $signed({{(MW-W){kd_ff[W-1]}}, kd_ff});
         end
         jpid_pkg::MS_S: begin
            mul_a = $signed({{(MW-W){sum_ff[W-1]}}, sum_ff});
            mul_b = $signed({{(MW-W){scale_ff[W-1]}}, scale_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = mul_a * mul_b;
   end

   assign fx_prod = prod_ff >>> FRAC_BITS;
   assign diff    = acc_ff - fx_prod;

   always_comb begin
      case (cmd.acc_op)
         jpid_pkg::ACC_LOAD: acc_in = fx_prod;
         jpid_pkg::ACC_ADD:  acc_in = acc_ff + fx_prod;
         default:            acc_in = acc_ff;
      endcase
   end

   assign drive_in = mode_ff ? '0 : sat_word(fx_prod);

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff    <= jpid_pkg::PROP_GAIN_RST;
         ki_ff    <= jpid_pkg::INTEG_GAIN_RST;
         kd_ff    <= jpid_pkg::DERIV_GAIN_RST;
         clamp_ff <= jpid_pkg::INTEG_CLAMP_RST;
         elim_ff  <= jpid_pkg::ERROR_LIMIT_RST;
         scale_ff <= jpid_pkg::OUT_SCALE_RST;
         thr_ff   <= jpid_pkg::PRESS_THR_RST;
         count_ff <= '0;
         mode_ff  <= 1'b0;
         integ_ff <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               jpid_pkg::CSR_PROP_GAIN:       kp_ff    <= csr_wdata;
               jpid_pkg::CSR_INTEG_GAIN:      ki_ff    <= csr_wdata;
               jpid_pkg::CSR_DERIV_GAIN:      kd_ff    <= csr_wdata;
               jpid_pkg::CSR_INTEG_CLAMP:     clamp_ff <= csr_wdata[jpid_pkg::LIMIT_W-1:0];
               jpid_pkg::CSR_ERROR_LIMIT:     elim_ff  <= csr_wdata[jpid_pkg::LIMIT_W-1:0];
               jpid_pkg::CSR_OUTPUT_SCALE:    scale_ff <= csr_wdata;
               jpid_pkg::CSR_PRESS_THRESHOLD: thr_ff   <= csr_wdata[jpid_pkg::CNT_W-1:0];
               default: ;
            endcase
         end
         count_ff <= count_in;
         mode_ff  <= mode_in;
         integ_ff <= integ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         angle_ff  <= req_joint_angle;
         vel_ff    <= req_joint_velocity;
         dt_ff     <= req_time_step;
         button_ff <= req_button_down;
      end
      if (cmd.prep) begin
         err_ff <= err_in;
      end
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.latch_idt) begin
         idt_ff <= sat_word(fx_prod);
      end
      acc_ff <= acc_in;
      if (cmd.latch_sum) begin
         sum_ff <= sat_word(diff);
      end
      if (cmd.out_load) begin
         drive_ff  <= drive_in;
         dvalid_ff <= !mode_ff;
         hyb_ff    <= mode_ff;
      end
   end

   assign rsp_drive       = drive_ff;
   assign rsp_drive_valid = dvalid_ff;
   assign rsp_hybrid_mode = hyb_ff;

endmodule

### sv/joint_pid_with_mode_toggle.sv
// Top level of the joint PID controller with button-driven mode toggle.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  operation, angle, velocity, time step, button
//   rsp_      out        rsp_valid / rsp_ready  drive, drive valid, hybrid mode
//   csr_      in         csr_write              csr_index, csr_wdata
//
// A request is accepted only while idle, and each runs to its end before the next is accepted;
// for a PID tick the single shared 33x33 multiplier runs five products in turn (integral*dt, P, I, D, scale).
// A hybrid-mode tick skips the products; a joystick request only steps the press count, with no result.
// Reset is synchronous: it clears mode, press count and integral and loads the
// register defaults. A result waits in the output register while the next
// request is worked on; that request stalls at its last step until the slot frees.
module joint_pid_with_mode_toggle #(
   parameter int FRAC_BITS = jpid_pkg::FRAC_BITS_DEF,
   parameter int ACC_WIDTH = jpid_pkg::ACC_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_operation,
   input  logic signed [jpid_pkg::WORD_W-1:0]   req_joint_angle,
   input  logic signed [jpid_pkg::WORD_W-1:0]   req_joint_velocity,
   input  logic [jpid_pkg::DT_W-1:0]            req_time_step,
   input  logic                                req_button_down,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [jpid_pkg::WORD_W-1:0]   rsp_drive,
   output logic                                rsp_drive_valid,
   output logic                                rsp_hybrid_mode,
   // register write port
   input  logic                                csr_write,
   input  logic [jpid_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [jpid_pkg::WORD_W-1:0]          csr_wdata
);

   // commands from the sequencer, mode status back from the datapath
   jpid_pkg::dp_cmd_type    cmd;
   jpid_pkg::dp_status_type status;

   // Sequence each request: latch it; a joystick steps the press count, a tick
   // updates the mode, runs the PID terms on the multiplier unless hybrid, and loads the output register.
   jpid_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .status        (status),
      .cmd           (cmd)
   );

   // Hold settings, integral, press count and mode; do all arithmetic.
   jpid_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_joint_angle    (req_joint_angle),
      .req_joint_velocity (req_joint_velocity),
      .req_time_step      (req_time_step),
      .req_button_down    (req_button_down),
      .rsp_drive          (rsp_drive),
      .rsp_drive_valid    (rsp_drive_valid),
      .rsp_hybrid_mode    (rsp_hybrid_mode)
   );

endmodule
